>>> rtl/pru_pkg.sv
// ----------------------------------------------------------------------------
// pru_pkg
// shared types, constants and helpers of the page replacement unit
// ----------------------------------------------------------------------------
package pru_pkg;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PT_RD,
        ST_PT_CHK,
        ST_HIT,
        ST_Q_WT,
        ST_QPT_WT,
        ST_DIV,
        ST_OWN_WT,
        ST_SCAN,
        ST_SCAN_END,
        ST_VIC_RD,
        ST_VIC_WT,
        ST_UNMAP,
        ST_PGOUT,
        ST_PGIN,
        ST_MAP
    } t_state;

    typedef enum logic [2:0] {
        EV_HIT   = 3'd0,
        EV_UNMAP = 3'd1,
        EV_OUT   = 3'd2,
        EV_IN    = 3'd3,
        EV_MAP   = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        POL_FIFO = 2'd0,
        POL_LRU  = 2'd1,
        POL_RAND = 2'd2,
        POL_RSVD = 2'd3
    } t_policy;

    localparam logic [1:0]  CFG_POLICY = 2'd0;
    localparam logic [1:0]  CFG_FRAMES = 2'd1;
    localparam logic [1:0]  CFG_SEED   = 2'd2;

    localparam logic [31:0] COST_MAP    = 32'd250;
    localparam logic [31:0] COST_UNMAP  = 32'd250;
    localparam logic [31:0] COST_XFER   = 32'd3000;
    localparam logic [31:0] COST_ACCESS = 32'd1;
    localparam logic [31:0] STAMP_NEVER = 32'hFFFF_FFFF;
    localparam logic [31:0] STAMP_MAX   = 32'hFFFF_FFFE;
    localparam logic [15:0] SEED_RESET  = 16'd44257;
    localparam logic [15:0] LFSR_MASK   = 16'hB400;
    localparam logic [5:0]  FRAMES_RESET = 6'd32;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

>>> rtl/pru_ram.sv
// ----------------------------------------------------------------------------
// pru_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module pru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/page_replacement_unit_top.sv
// ----------------------------------------------------------------------------
// page_replacement_unit_top
// demand paging unit with fifo, lru and random victim choice
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one access word: tuser[0] is_write, tdata[5:0] page.
//   m_axis carries event words: tuser[2:0] event kind, tdata holds page,
//   frame and the fault, transfer and cost totals; tlast marks the final
//   event of an access. the cfg port writes policy, frame count and seed
//   (the seed write reloads the lfsr); the user must write it only while the
//   unit is idle, the unit itself does not enforce this. after reset a
//   clearing pass sweeps the page table and the stamp memory; no access
//   word is taken during it. an eviction adds the victim search: fifo
//   reads the queue, page table and owner memory in turn, random takes the
//   bit-serial remainder of the lfsr by the frame count, lru scans with one
//   stamp memory read a cycle; the victim entry is then read and 3 or 4
//   event words follow.
//   a single output register holds the event word; when the receiver stalls
//   the sequencer waits in its event state, and the next access word can be
//   taken while the final event word is still waiting.
// ----------------------------------------------------------------------------
module page_replacement_unit_top #(
    parameter int PAGES      = 64,
    parameter int MAX_FRAMES = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // page[5:0], zero pad
    input  logic [0:0]   s_axis_tuser,   // is_write
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,   // page[5:0], frame[10:6], fault[42:11],
                                         // transfer[74:43], cost[106:75], zero pad
    output logic [2:0]   m_axis_tuser,   // event_kind
    output logic         m_axis_tlast,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data
);
    localparam int PW = $clog2(PAGES);
    localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NW = $clog2(MAX_FRAMES + 1);
    localparam int EW = FW + 2;   // page entry: valid, dirty, frame

    pru_pkg::t_state r_state, n_state;

    // configuration
    logic [1:0]  r_policy;
    logic [5:0]  r_frames;
    logic [5:0]  w_nf;

    // control state
    logic [PW-1:0] r_clr;
    logic [FW-1:0] r_head, r_tail;
    logic [NW-1:0] r_nff;
    logic [31:0]   r_acc;
    logic [15:0]   r_lfsr;
    logic [31:0]   r_fault, r_xfer, r_cost;
    logic          r_ov;

    // per-access working registers
    logic          r_wr;
    logic [PW-1:0] r_pg;
    logic [31:0]   r_stamp;
    logic [FW-1:0] r_fr;
    logic          r_dirty;
    logic [PW-1:0] r_victim;
    logic [31:0]   r_best;
    logic [PW-1:0] r_idx, r_didx;
    logic          r_dv;
    logic [6:0]    r_rem;
    logic [3:0]    r_bit;

    // output word
    logic [2:0]    r_o_kind;
    logic [5:0]    r_o_page;
    logic [4:0]    r_o_frame;
    logic          r_o_last;
    logic [31:0]   r_o_fault, r_o_xfer, r_o_cost;

    // memory ports
    logic          pt_we, lu_we, rq_we, ow_we;
    logic [PW-1:0] pt_waddr, pt_raddr, lu_waddr, lu_raddr;
    logic [EW-1:0] pt_wdata, pt_q;
    logic [31:0]   lu_wdata, lu_q;
    logic [FW-1:0] rq_waddr, rq_raddr, ow_waddr, ow_raddr;
    logic [PW-1:0] rq_wdata, rq_q, ow_wdata, ow_q;

    logic [PW-1:0] w_pg_lut [64];
    logic          w_accept, w_emit_st, w_out_free, w_fire, w_free;
    logic [6:0]    w_rsh, w_rnx;
    logic [15:0]   w_lfsr_step;

    // page number modulo PAGES as a constant table
    for (genvar g = 0; g < 64; g++) begin : g_pg_lut
        assign w_pg_lut[g] = PW'(g % PAGES);
    end

    // effective frame count: zero acts as one, clipped to MAX_FRAMES
    always_comb begin
        if (r_frames == 6'd0) begin
            w_nf = 6'd1;
        end else if (int'(r_frames) > MAX_FRAMES) begin
            w_nf = 6'(MAX_FRAMES);
        end else begin
            w_nf = r_frames;
        end
    end

    assign w_free      = (int'(r_nff) < int'(w_nf)) && (int'(r_nff) < MAX_FRAMES);
    assign w_lfsr_step = r_lfsr[0] ? ((r_lfsr >> 1) ^ pru_pkg::LFSR_MASK) : (r_lfsr >> 1);
    // one restoring step of lfsr mod frame count
    assign w_rsh       = {r_rem[5:0], r_lfsr[r_bit]};
    assign w_rnx       = (w_rsh >= {1'b0, w_nf}) ? (w_rsh - {1'b0, w_nf}) : w_rsh;

    assign w_out_free  = !r_ov || m_axis_tready;
    assign w_emit_st   = (r_state == pru_pkg::ST_HIT)   || (r_state == pru_pkg::ST_UNMAP) ||
                         (r_state == pru_pkg::ST_PGOUT) || (r_state == pru_pkg::ST_PGIN)  ||
                         (r_state == pru_pkg::ST_MAP);
    assign w_fire      = w_emit_st && w_out_free;
    assign w_accept    = s_axis_tvalid && s_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pru_pkg::ST_CLEAR:    if (r_clr == PW'(PAGES - 1)) n_state = pru_pkg::ST_IDLE;
            pru_pkg::ST_IDLE:     if (s_axis_tvalid) n_state = pru_pkg::ST_PT_RD;
            pru_pkg::ST_PT_RD:    n_state = pru_pkg::ST_PT_CHK;
            pru_pkg::ST_PT_CHK: begin
                if (pt_q[EW-1]) begin
                    n_state = pru_pkg::ST_HIT;
                end else if (w_free) begin
                    n_state = pru_pkg::ST_PGIN;
                end else begin
                    case (r_policy)
                        pru_pkg::POL_LRU:  n_state = pru_pkg::ST_SCAN;
                        pru_pkg::POL_RAND: n_state = pru_pkg::ST_DIV;
                        default:           n_state = pru_pkg::ST_Q_WT;
                    endcase
                end
            end
            pru_pkg::ST_HIT:      if (w_out_free) n_state = pru_pkg::ST_IDLE;
            pru_pkg::ST_Q_WT:     n_state = pru_pkg::ST_QPT_WT;
            pru_pkg::ST_QPT_WT:   n_state = pru_pkg::ST_OWN_WT;
            pru_pkg::ST_DIV:      if (r_bit == 4'd0) n_state = pru_pkg::ST_OWN_WT;
            pru_pkg::ST_OWN_WT:   n_state = pru_pkg::ST_VIC_RD;
            pru_pkg::ST_SCAN:     if (r_idx == PW'(PAGES - 1)) n_state = pru_pkg::ST_SCAN_END;
            pru_pkg::ST_SCAN_END: n_state = pru_pkg::ST_VIC_RD;
            pru_pkg::ST_VIC_RD:   n_state = pru_pkg::ST_VIC_WT;
            pru_pkg::ST_VIC_WT:   n_state = pru_pkg::ST_UNMAP;
            pru_pkg::ST_UNMAP: begin
                if (w_out_free) n_state = r_dirty ? pru_pkg::ST_PGOUT : pru_pkg::ST_PGIN;
            end
            pru_pkg::ST_PGOUT:    if (w_out_free) n_state = pru_pkg::ST_PGIN;
            pru_pkg::ST_PGIN:     if (w_out_free) n_state = pru_pkg::ST_MAP;
            pru_pkg::ST_MAP:      if (w_out_free) n_state = pru_pkg::ST_IDLE;
            default:              n_state = pru_pkg::ST_IDLE;
        endcase
    end

    // memory controls and handshake
    always_comb begin
        s_axis_tready = (r_state == pru_pkg::ST_IDLE);
        pt_we = 1'b0; pt_waddr = r_pg; pt_wdata = '0; pt_raddr = r_pg;
        lu_we = 1'b0; lu_waddr = r_pg; lu_wdata = r_stamp; lu_raddr = r_idx;
        rq_we = 1'b0; rq_waddr = r_tail; rq_wdata = r_pg; rq_raddr = r_head;
        ow_we = 1'b0; ow_waddr = r_fr; ow_wdata = r_pg; ow_raddr = r_fr;
        case (r_state)
            pru_pkg::ST_CLEAR: begin
                pt_we = 1'b1; pt_waddr = r_clr; pt_wdata = '0;
                lu_we = 1'b1; lu_waddr = r_clr; lu_wdata = pru_pkg::STAMP_NEVER;
            end
            pru_pkg::ST_HIT: begin
                pt_we    = w_fire;
                pt_wdata = {1'b1, r_dirty | r_wr, r_fr};
                lu_we    = w_fire;
            end
            pru_pkg::ST_Q_WT:   pt_raddr = rq_q;
            pru_pkg::ST_QPT_WT: ow_raddr = pt_q[FW-1:0];
            pru_pkg::ST_DIV:    ow_raddr = FW'(w_rnx);
            pru_pkg::ST_VIC_RD: pt_raddr = r_victim;
            pru_pkg::ST_UNMAP: begin
                // frame field is kept: a stale queue entry still reads it
                pt_we    = w_fire; pt_waddr = r_victim; pt_wdata = {2'b00, r_fr};
                lu_we    = w_fire; lu_waddr = r_victim; lu_wdata = pru_pkg::STAMP_NEVER;
            end
            pru_pkg::ST_PGIN:   rq_we = w_fire;
            pru_pkg::ST_MAP: begin
                pt_we    = w_fire; pt_wdata = {1'b1, r_wr, r_fr};
                lu_we    = w_fire;
                ow_we    = w_fire;
            end
            default: ;
        endcase
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pru_pkg::ST_CLEAR;
            r_policy <= pru_pkg::POL_FIFO;
            r_frames <= pru_pkg::FRAMES_RESET;
            r_lfsr   <= pru_pkg::SEED_RESET;
            r_clr    <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_nff    <= '0;
            r_acc    <= 32'd1;
            r_fault  <= '0;
            r_xfer   <= '0;
            r_cost   <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pru_pkg::CFG_POLICY: r_policy <= i_cfg_data[1:0];
                    pru_pkg::CFG_FRAMES: r_frames <= i_cfg_data[5:0];
                    pru_pkg::CFG_SEED:   r_lfsr   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_fire) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                pru_pkg::ST_CLEAR: r_clr <= r_clr + PW'(1);
                pru_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        r_wr    <= s_axis_tuser[0];
                        r_pg    <= w_pg_lut[s_axis_tdata[5:0]];
                        r_stamp <= r_acc;
                        if (r_acc < pru_pkg::STAMP_MAX) r_acc <= r_acc + 32'd1;
                    end
                end
                pru_pkg::ST_PT_CHK: begin
                    r_dirty <= pt_q[EW-2];
                    if (pt_q[EW-1]) begin
                        r_fr <= pt_q[FW-1:0];
                    end else begin
                        r_fault <= pru_pkg::sat_add(r_fault, 32'd1);
                        if (w_free) begin
                            r_fr  <= FW'(r_nff);
                            r_nff <= r_nff + NW'(1);
                        end else begin
                            r_fr     <= pt_q[FW-1:0];
                            r_head   <= (r_head == FW'(MAX_FRAMES - 1)) ? '0 : r_head + FW'(1);
                            r_best   <= pru_pkg::STAMP_NEVER;
                            r_victim <= '0;
                            r_idx    <= '0;
                            r_dv     <= 1'b0;
                            r_rem    <= '0;
                            r_bit    <= 4'd15;
                            if (r_policy == pru_pkg::POL_RAND) r_lfsr <= w_lfsr_step;
                        end
                    end
                end
                pru_pkg::ST_QPT_WT: r_fr <= pt_q[FW-1:0];
                pru_pkg::ST_DIV: begin
                    r_rem <= w_rnx;
                    r_bit <= r_bit - 4'd1;
                    if (r_bit == 4'd0) r_fr <= FW'(w_rnx);
                end
                pru_pkg::ST_OWN_WT: r_victim <= ow_q;
                pru_pkg::ST_SCAN, pru_pkg::ST_SCAN_END: begin
                    // stamp data is a registered read and belongs to the previous address
                    if (r_dv && (lu_q < r_best)) begin
                        r_best   <= lu_q;
                        r_victim <= r_didx;
                    end
                    r_dv   <= (r_state == pru_pkg::ST_SCAN);
                    r_didx <= r_idx;
                    r_idx  <= r_idx + PW'(1);
                end
                pru_pkg::ST_VIC_WT: begin
                    r_dirty <= pt_q[EW-2];
                    if (r_policy == pru_pkg::POL_LRU) r_fr <= pt_q[FW-1:0];
                end
                pru_pkg::ST_UNMAP: begin
                    if (w_fire) r_cost <= pru_pkg::sat_add(r_cost, pru_pkg::COST_UNMAP);
                end
                pru_pkg::ST_PGOUT, pru_pkg::ST_PGIN: begin
                    if (w_fire) begin
                        r_cost <= pru_pkg::sat_add(r_cost, pru_pkg::COST_XFER);
                        r_xfer <= pru_pkg::sat_add(r_xfer, 32'd1);
                        if (r_state == pru_pkg::ST_PGIN) begin
                            r_tail <= (r_tail == FW'(MAX_FRAMES - 1)) ? '0 : r_tail + FW'(1);
                        end
                    end
                end
                pru_pkg::ST_HIT: begin
                    if (w_fire) r_cost <= pru_pkg::sat_add(r_cost, pru_pkg::COST_ACCESS);
                end
                pru_pkg::ST_MAP: begin
                    if (w_fire) begin
                        r_cost <= pru_pkg::sat_add(pru_pkg::sat_add(r_cost, pru_pkg::COST_MAP),
                                                   pru_pkg::COST_ACCESS);
                    end
                end
                default: ;
            endcase
        end
    end

    // output word, totals as they stand after the event
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_o_frame <= 5'(r_fr);
            r_o_fault <= r_fault;
            case (r_state)
                pru_pkg::ST_HIT: begin
                    r_o_kind <= pru_pkg::EV_HIT;
                    r_o_last <= 1'b1;
                    r_o_page <= 6'(r_pg);
                    r_o_xfer <= r_xfer;
                    r_o_cost <= pru_pkg::sat_add(r_cost, pru_pkg::COST_ACCESS);
                end
                pru_pkg::ST_UNMAP: begin
                    r_o_kind <= pru_pkg::EV_UNMAP;
                    r_o_last <= 1'b0;
                    r_o_page <= 6'(r_victim);
                    r_o_xfer <= r_xfer;
                    r_o_cost <= pru_pkg::sat_add(r_cost, pru_pkg::COST_UNMAP);
                end
                pru_pkg::ST_PGOUT: begin
                    r_o_kind <= pru_pkg::EV_OUT;
                    r_o_last <= 1'b0;
                    r_o_page <= 6'(r_victim);
                    r_o_xfer <= pru_pkg::sat_add(r_xfer, 32'd1);
                    r_o_cost <= pru_pkg::sat_add(r_cost, pru_pkg::COST_XFER);
                end
                pru_pkg::ST_PGIN: begin
                    r_o_kind <= pru_pkg::EV_IN;
                    r_o_last <= 1'b0;
                    r_o_page <= 6'(r_pg);
                    r_o_xfer <= pru_pkg::sat_add(r_xfer, 32'd1);
                    r_o_cost <= pru_pkg::sat_add(r_cost, pru_pkg::COST_XFER);
                end
                default: begin
                    r_o_kind <= pru_pkg::EV_MAP;
                    r_o_last <= 1'b1;
                    r_o_page <= 6'(r_pg);
                    r_o_xfer <= r_xfer;
                    r_o_cost <= pru_pkg::sat_add(pru_pkg::sat_add(r_cost, pru_pkg::COST_MAP),
                                                 pru_pkg::COST_ACCESS);
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_o_kind;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = {5'd0, r_o_cost, r_o_xfer, r_o_fault, r_o_frame, r_o_page};

    // page table: valid, dirty, frame
    pru_ram #(.WIDTH(EW), .DEPTH(PAGES)) u_pt_ram (
        .i_clk(i_clk), .i_we(pt_we), .i_waddr(pt_waddr), .i_wdata(pt_wdata),
        .i_raddr(pt_raddr), .o_rdata(pt_q)
    );

    // last-use stamps
    pru_ram #(.WIDTH(32), .DEPTH(PAGES)) u_lu_ram (
        .i_clk(i_clk), .i_we(lu_we), .i_waddr(lu_waddr), .i_wdata(lu_wdata),
        .i_raddr(lu_raddr), .o_rdata(lu_q)
    );

    // resident page queue
    pru_ram #(.WIDTH(PW), .DEPTH(MAX_FRAMES)) u_rq_ram (
        .i_clk(i_clk), .i_we(rq_we), .i_waddr(rq_waddr), .i_wdata(rq_wdata),
        .i_raddr(rq_raddr), .o_rdata(rq_q)
    );

    // frame owner table
    pru_ram #(.WIDTH(PW), .DEPTH(MAX_FRAMES)) u_ow_ram (
        .i_clk(i_clk), .i_we(ow_we), .i_waddr(ow_waddr), .i_wdata(ow_wdata),
        .i_raddr(ow_raddr), .o_rdata(ow_q)
    );

    // no event word during the clearing pass
    a_no_out_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pru_pkg::ST_CLEAR) |-> !m_axis_tvalid)
        else $error("event word during clearing pass");

    // a hit is always the final word of its access
    a_hit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == pru_pkg::EV_HIT)) |-> m_axis_tlast)
        else $error("hit word without tlast");

    // fault total never goes down
    a_fault_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_fault >= $past(r_fault)))
        else $error("fault count decreased");

    // free frame pointer never exceeds the frame store size
    a_nff_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_nff) <= MAX_FRAMES)
        else $error("free frame pointer out of range");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the page replacement unit: a paging predictor
// works out the event words of every accepted access and the monitor
// compares each event word field by field, across all victim policies
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        pru_pkg::t_event kind;
        logic [5:0]  page;
        logic [4:0]  frame;
        logic        last;
        logic [31:0] faults;
        logic [31:0] transfers;
        logic [31:0] cost;
    } t_paging_event;

    // paging predictor plus the store of event words still to come
    class t_paging_scoreboard;
        bit          pg_valid [64];
        bit          pg_dirty [64];
        bit [4:0]    pg_frame [64];
        bit [31:0]   pg_stamp [64];
        bit [5:0]    fifo_pages [32];
        bit [5:0]    owner [32];
        bit [4:0]    q_head;
        bit [4:0]    q_tail;
        bit [5:0]    free_frame;
        bit [31:0]   use_count;
        bit [15:0]   lfsr;
        bit [31:0]   faults;
        bit [31:0]   transfers;
        bit [31:0]   cost;
        pru_pkg::t_policy policy;
        bit [5:0]    frames;
        t_paging_event pending_events[$];
        int          errors;

        function new();
            for (int i = 0; i < 64; i++) begin
                pg_valid[i] = 1'b0;
                pg_dirty[i] = 1'b0;
                pg_frame[i] = '0;
                pg_stamp[i] = pru_pkg::STAMP_NEVER;
            end
            q_head = '0;
            q_tail = '0;
            free_frame = '0;
            use_count = 32'd1;
            lfsr = pru_pkg::SEED_RESET;
            faults = '0;
            transfers = '0;
            cost = '0;
            policy = pru_pkg::POL_FIFO;
            frames = pru_pkg::FRAMES_RESET;
            errors = 0;
        endfunction

        function bit [31:0] add_sat(bit [31:0] a, bit [31:0] b);
            bit [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? pru_pkg::STAMP_NEVER : s[31:0];
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] value);
            case (idx)
                pru_pkg::CFG_POLICY: policy = pru_pkg::t_policy'(value[1:0]);
                pru_pkg::CFG_FRAMES: frames = value[5:0];
                pru_pkg::CFG_SEED:   lfsr = value;
                default: ;
            endcase
        endfunction

        function void push(pru_pkg::t_event kind, bit [5:0] pg, bit [4:0] fr, bit last);
            t_paging_event e;
            e.kind = kind;
            e.page = pg;
            e.frame = fr;
            e.last = last;
            e.faults = faults;
            e.transfers = transfers;
            e.cost = cost;
            pending_events.insert(pending_events.size(), e);
        endfunction

        // predicts the event words of one access word
        function void note_access(bit wr, bit [5:0] pg);
            int unsigned nf;
            bit [31:0] stamp;
            bit [31:0] best;
            bit [5:0] victim;
            bit [5:0] qpage;
            bit [4:0] fr;
            bit was_dirty;
            nf = (frames == 0) ? 1 : (frames > 32) ? 32 : frames;
            stamp = use_count;
            if (use_count < pru_pkg::STAMP_MAX) use_count++;
            if (pg_valid[pg]) begin
                if (wr) pg_dirty[pg] = 1'b1;
                pg_stamp[pg] = stamp;
                cost = add_sat(cost, pru_pkg::COST_ACCESS);
                push(pru_pkg::EV_HIT, pg, pg_frame[pg], 1'b1);
                return;
            end
            faults = add_sat(faults, 32'd1);
            if (free_frame < nf) begin
                fr = free_frame[4:0];
                free_frame++;
            end else begin
                qpage = fifo_pages[q_head];
                q_head++;
                if (policy == pru_pkg::POL_LRU) begin
                    best = pru_pkg::STAMP_NEVER;
                    victim = '0;
                    for (int i = 0; i < 64; i++) begin
                        if (pg_stamp[i] < best) begin
                            best = pg_stamp[i];
                            victim = 6'(i);
                        end
                    end
                    fr = pg_frame[victim];
                end else if (policy == pru_pkg::POL_RAND) begin
                    lfsr = lfsr[0] ? ((lfsr >> 1) ^ pru_pkg::LFSR_MASK) : (lfsr >> 1);
                    fr = 5'(lfsr % nf);
                    victim = owner[fr];
                end else begin
                    // fifo and the spare code both take the queue head
                    fr = pg_frame[qpage];
                    victim = owner[fr];
                end
                cost = add_sat(cost, pru_pkg::COST_UNMAP);
                push(pru_pkg::EV_UNMAP, victim, fr, 1'b0);
                was_dirty = pg_dirty[victim];
                pg_valid[victim] = 1'b0;
                pg_dirty[victim] = 1'b0;
                pg_stamp[victim] = pru_pkg::STAMP_NEVER;
                if (was_dirty) begin
                    cost = add_sat(cost, pru_pkg::COST_XFER);
                    transfers = add_sat(transfers, 32'd1);
                    push(pru_pkg::EV_OUT, victim, fr, 1'b0);
                end
            end
            cost = add_sat(cost, pru_pkg::COST_XFER);
            transfers = add_sat(transfers, 32'd1);
            push(pru_pkg::EV_IN, pg, fr, 1'b0);
            fifo_pages[q_tail] = pg;
            q_tail++;
            pg_valid[pg] = 1'b1;
            pg_dirty[pg] = wr;
            pg_frame[pg] = fr;
            owner[fr] = pg;
            pg_stamp[pg] = stamp;
            cost = add_sat(cost, pru_pkg::COST_MAP);
            cost = add_sat(cost, pru_pkg::COST_ACCESS);
            push(pru_pkg::EV_MAP, pg, fr, 1'b1);
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: mismatch on %s, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_event(t_paging_event got);
            t_paging_event want;
            if (pending_events.size() == 0) begin
                errors++;
                $display("%0t: unexpected event word, expected none, actual kind %0d page %0d",
                         $time, got.kind, got.page);
                return;
            end
            want = pending_events[0];
            pending_events.delete(0);
            compare("event_kind", 32'(want.kind), 32'(got.kind));
            compare("event_page", 32'(want.page), 32'(got.page));
            compare("event_frame", 32'(want.frame), 32'(got.frame));
            compare("last", 32'(want.last), 32'(got.last));
            compare("fault_total", want.faults, got.faults);
            compare("transfer_total", want.transfers, got.transfers);
            compare("cost_total", want.cost, got.cost);
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;    // page[5:0], zero pad
    logic [0:0]   s_axis_tuser;    // is_write
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;    // page, frame, fault, transfer, cost, zero pad
    logic [2:0]   m_axis_tuser;    // event_kind
    logic         m_axis_tlast;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_idx;
    logic [15:0]  i_cfg_data;

    t_paging_scoreboard sb;
    int src_idle_pct;   // chance in a hundred that the sender idles a cycle
    int snk_idle_pct;   // same for the receiver
    int hold_left;      // long receiver hold-off, counted down per cycle
    int cycles = 0;

    page_replacement_unit_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver side: ready changes on the falling edge only
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // monitor: every accepted event word goes to the scoreboard
    always @(posedge i_clk) begin
        t_paging_event got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind = pru_pkg::t_event'(m_axis_tuser);
            got.page = m_axis_tdata[5:0];
            got.frame = m_axis_tdata[10:6];
            got.last = m_axis_tlast;
            got.faults = m_axis_tdata[42:11];
            got.transfers = m_axis_tdata[74:43];
            got.cost = m_axis_tdata[106:75];
            sb.check_event(got);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // offer one access word, with random idle cycles ahead of it
    task automatic send_access(input bit wr, input bit [5:0] pg);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {2'b00, pg};
        s_axis_tuser = wr;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_access(wr, pg);
    endtask

    // register write, only called while no access is in flight
    task automatic write_cfg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = value;
        sb.write_reg(idx, value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // wait out every expected word, then the longest search time
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one setting and a stretch of random accesses over a working set
    task automatic run_phase(input pru_pkg::t_policy pol, input logic [5:0] nfr,
                             input logic [15:0] seed, input int count, input int set_top);
        bit [5:0] pg;
        wait_drained();
        write_cfg(pru_pkg::CFG_POLICY, 16'(pol));
        write_cfg(pru_pkg::CFG_FRAMES, 16'(nfr));
        write_cfg(pru_pkg::CFG_SEED, seed);
        for (int n = 0; n < count; n++) begin
            // mostly a tight working set so hits and evictions mix, some noise
            if ($urandom_range(9) == 0) pg = 6'($urandom_range(63));
            else pg = 6'($urandom_range(set_top));
            send_access(1'($urandom_range(1)), pg);
        end
    endtask

    initial begin
        sb = new();
        hold_left = 0;
        src_idle_pct = 36;
        snk_idle_pct = 68;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: two frames, fifo, dirty and clean victims, page extremes
        write_cfg(pru_pkg::CFG_FRAMES, 16'd2);
        send_access(1'b0, 6'd0);
        send_access(1'b1, 6'd63);
        send_access(1'b1, 6'd0);
        send_access(1'b0, 6'd5);
        send_access(1'b0, 6'd63);
        send_access(1'b1, 6'd7);
        send_access(1'b0, 6'd7);
        send_access(1'b0, 6'd0);
        send_access(1'b1, 6'd42);
        send_access(1'b0, 6'd21);

        // mixed-policy phases, sender idling more lightly first
        run_phase(pru_pkg::POL_FIFO, 6'd4, 16'd44257, 40, 8);
        run_phase(pru_pkg::POL_LRU, 6'd6, 16'd1, 40, 12);
        run_phase(pru_pkg::POL_RAND, 6'd5, 16'd1, 40, 10);

        src_idle_pct = 68;
        snk_idle_pct = 36;
        // zero frame count acts as one frame, spare policy acts as fifo
        run_phase(pru_pkg::POL_RSVD, 6'd0, 16'd12345, 25, 4);
        // sender keeps offering while the receiver holds off for a long time
        hold_left = 400;
        src_idle_pct = 0;
        run_phase(pru_pkg::POL_LRU, 6'd63, 16'd777, 40, 63);
        src_idle_pct = 68;
        // zero seed pins the random victim to frame 0
        run_phase(pru_pkg::POL_RAND, 6'd32, 16'd0, 40, 63);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_phase(pru_pkg::POL_RAND, 6'd3, 16'hFFFF, 30, 6);
        run_phase(pru_pkg::POL_FIFO, 6'd1, 16'd2, 25, 3);
        run_phase(pru_pkg::POL_LRU, 6'd2, 16'd3, 40, 5);

        wait_drained();
        if (sb.errors == 0 && sb.pending_events.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/pru_pkg.sv
rtl/pru_ram.sv
rtl/page_replacement_unit_top.sv
tb/tb_top.sv
